>>> src/rti_pkg.sv
// Package with the constants shared by the ray-triangle intersection files.
`timescale 1ns / 1ps
package rti_pkg;
   localparam int FIELD_W    = 60;
   localparam int DIST_FRAC  = 16;
   localparam int QUO_BITS   = 32;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = 4;
   localparam int FIFO_CW    = 5;
endpackage

>>> src/ray_triangle_intersect.sv
// Top level of the fixed-point ray-triangle intersection block.
`timescale 1ns / 1ps
// Each request carries one ray and one triangle as packed signed coordinates and
// returns one result: hit, the distance t in unsigned Q16.16 and the hit point.
// The block takes one request per clock cycle when the result side keeps up.
// The path runs through the front pipeline for the exact cross and dot products,
// the request queue, the multiply and compare stages, the pipelined restoring
// divider that forms the distance and the three hit point offsets at one quotient
// bit per stage, and the result register. The request queue holds sixteen
// requests, and req_ready keeps the number of requests accepted but not yet
// popped by the back pipeline within that depth.
module ray_triangle_intersect import rti_pkg::*; #(
   parameter int COORD_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [FIELD_W-1:0] req_ray_origin,
   input  logic [FIELD_W-1:0] req_ray_direction,
   input  logic [FIELD_W-1:0] req_vertex_a,
   input  logic [FIELD_W-1:0] req_vertex_b,
   input  logic [FIELD_W-1:0] req_vertex_c,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [31:0]        rsp_hit_distance,
   output logic [FIELD_W-1:0] rsp_hit_point
);
   localparam int PW = 2 * (3 * COORD_BITS + 7) + 6 * COORD_BITS + 4;

   logic               accept;
   logic               push, pop, empty;
   logic [PW-1:0]      push_data, head;
   logic [FIFO_CW-1:0] inflight_ff, inflight_in;

   assign req_ready = (inflight_ff < FIFO_CW'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;

   always_comb begin
      inflight_in = inflight_ff + FIFO_CW'(accept) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   rti_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .ray_origin    (req_ray_origin),
      .ray_direction (req_ray_direction),
      .vertex_a      (req_vertex_a),
      .vertex_b      (req_vertex_b),
      .vertex_c      (req_vertex_c),
      .push          (push),
      .push_data     (push_data)
   );

   rti_fifo #(
      .WIDTH (PW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   rti_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_hit_distance (rsp_hit_distance),
      .rsp_hit_point    (rsp_hit_point)
   );
endmodule

>>> src/rti_front.sv
// Front pipeline: edges, cross and dot products, determinant and hit classification.
`timescale 1ns / 1ps
module rti_front import rti_pkg::*; #(
   parameter int COORD_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [FIELD_W-1:0]     ray_origin,
   input  logic [FIELD_W-1:0]     ray_direction,
   input  logic [FIELD_W-1:0]     vertex_a,
   input  logic [FIELD_W-1:0]     vertex_b,
   input  logic [FIELD_W-1:0]     vertex_c,
   output logic                   push,
   output logic [2*(3*COORD_BITS+7)+6*COORD_BITS+3:0] push_data
);
   localparam int C  = COORD_BITS;
   localparam int EW = C + 1;
   localparam int PH = 2 * C + 1;
   localparam int PQ = 2 * C + 2;
   localparam int HW = 2 * C + 2;
   localparam int QW = 2 * C + 3;
   localparam int L  = C + 1;
   localparam int SW = C + 2;
   localparam int PL = 2 * C + 3;
   localparam int DW = 3 * C + 7;
   localparam int XW = 3 * C + FIELD_W;
   localparam int DOT_DET = 0;
   localparam int DOT_NU  = 1;
   localparam int DOT_NV  = 2;
   localparam int DOT_NT  = 3;
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   logic                  v_ff  [1:7];
   logic                  v_in  [1:7];
   logic signed [C-1:0]   o_ff  [1:7][3];
   logic signed [C-1:0]   d_ff  [1:7][3];
   logic signed [EW-1:0]  e1_ff [1:3][3];
   logic signed [EW-1:0]  e2_ff [1:3][3];
   logic signed [EW-1:0]  s_ff  [1:3][3];
   logic signed [PH-1:0]  hp_ff [3][2];
   logic signed [PQ-1:0]  qp_ff [3][2];
   logic signed [HW-1:0]  h_ff  [3];
   logic signed [QW-1:0]  q_ff  [3];
   logic signed [PL-1:0]  pl_ff [4][3];
   logic signed [PL-1:0]  ph_ff [4][3];
   logic signed [DW-1:0]  tm_ff [4][3];
   logic signed [DW-1:0]  sm_ff [4];
   logic signed [DW-1:0]  n_ff  [4];
   logic                  detz_ff;
   logic                  push_ff;
   logic [$bits(push_data)-1:0] data_ff;

   logic signed [C-1:0]   oc [3], dc [3], ac [3], bc [3], cc [3];
   logic [XW-1:0]         xo, xd, xa, xb, xc;

   always_comb begin
      xo = {{(3*C){1'b0}}, ray_origin};
      xd = {{(3*C){1'b0}}, ray_direction};
      xa = {{(3*C){1'b0}}, vertex_a};
      xb = {{(3*C){1'b0}}, vertex_b};
      xc = {{(3*C){1'b0}}, vertex_c};
      for (int k = 0; k < 3; k++) begin
         oc[k] = $signed(xo[k*C +: C]);
         dc[k] = $signed(xd[k*C +: C]);
         ac[k] = $signed(xa[k*C +: C]);
         bc[k] = $signed(xb[k*C +: C]);
         cc[k] = $signed(xc[k*C +: C]);
      end
   end

   always_comb begin
      v_in[1] = in_valid;
      for (int i = 2; i <= 7; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 7; i++) begin
            v_ff[i] <= 1'b0;
         end
         push_ff <= 1'b0;
      end else begin
         for (int i = 1; i <= 7; i++) begin
            v_ff[i] <= v_in[i];
         end
         push_ff <= v_ff[7];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         o_ff[1][k]  <= oc[k];
         d_ff[1][k]  <= dc[k];
         e1_ff[1][k] <= EW'(bc[k]) - EW'(ac[k]);
         e2_ff[1][k] <= EW'(cc[k]) - EW'(ac[k]);
         s_ff[1][k]  <= EW'(oc[k]) - EW'(ac[k]);
         for (int i = 2; i <= 7; i++) begin
            o_ff[i][k] <= o_ff[i-1][k];
            d_ff[i][k] <= d_ff[i-1][k];
         end
         for (int i = 2; i <= 3; i++) begin
            e1_ff[i][k] <= e1_ff[i-1][k];
            e2_ff[i][k] <= e2_ff[i-1][k];
            s_ff[i][k]  <= s_ff[i-1][k];
         end
         hp_ff[k][0] <= PH'(d_ff[1][NXT[k]]) * PH'(e2_ff[1][PRV[k]]);
         hp_ff[k][1] <= PH'(d_ff[1][PRV[k]]) * PH'(e2_ff[1][NXT[k]]);
         qp_ff[k][0] <= PQ'(s_ff[1][NXT[k]]) * PQ'(e1_ff[1][PRV[k]]);
         qp_ff[k][1] <= PQ'(s_ff[1][PRV[k]]) * PQ'(e1_ff[1][NXT[k]]);
         h_ff[k] <= HW'(hp_ff[k][0]) - HW'(hp_ff[k][1]);
         q_ff[k] <= QW'(qp_ff[k][0]) - QW'(qp_ff[k][1]);
      end
   end

   logic signed [QW-1:0] yv [4][3];
   logic signed [EW-1:0] xv [4][3];
   logic signed [SW-1:0] ylo [4][3];
   logic signed [SW-1:0] yhi [4][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         yv[DOT_DET][k] = QW'(h_ff[k]);
         yv[DOT_NU][k]  = QW'(h_ff[k]);
         yv[DOT_NV][k]  = q_ff[k];
         yv[DOT_NT][k]  = q_ff[k];
         xv[DOT_DET][k] = e1_ff[3][k];
         xv[DOT_NU][k]  = s_ff[3][k];
         xv[DOT_NV][k]  = EW'(d_ff[3][k]);
         xv[DOT_NT][k]  = e2_ff[3][k];
         for (int m = 0; m < 4; m++) begin
            ylo[m][k] = $signed({1'b0, yv[m][k][L-1:0]});
            yhi[m][k] = $signed(yv[m][k][QW-1:L]);
         end
      end
   end

   logic signed [DW-1:0] ns [4];
   logic                 dneg;

   always_comb begin
      dneg = sm_ff[DOT_DET][DW-1];
      for (int m = 0; m < 4; m++) begin
         ns[m] = dneg ? -sm_ff[m] : sm_ff[m];
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < 4; m++) begin
         for (int k = 0; k < 3; k++) begin
            pl_ff[m][k] <= PL'(xv[m][k]) * PL'(ylo[m][k]);
            ph_ff[m][k] <= PL'(xv[m][k]) * PL'(yhi[m][k]);
            tm_ff[m][k] <= (DW'(ph_ff[m][k]) <<< L) + DW'(pl_ff[m][k]);
         end
         sm_ff[m] <= tm_ff[m][0] + tm_ff[m][1] + tm_ff[m][2];
         n_ff[m]  <= ns[m];
      end
      detz_ff <= (sm_ff[DOT_DET] == '0);
   end

   logic signed [DW:0]  nuv;
   logic                miss;
   logic [2:0]          dn;
   logic [3*C-1:0]      dabs;
   logic [3*C-1:0]      opk;

   always_comb begin
      nuv  = (DW+1)'(n_ff[DOT_NU]) + (DW+1)'(n_ff[DOT_NV]);
      miss = detz_ff
          || n_ff[DOT_NU] < 0
          || n_ff[DOT_DET] < n_ff[DOT_NU]
          || n_ff[DOT_NV] < 0
          || (DW+1)'(n_ff[DOT_DET]) < nuv
          || n_ff[DOT_NT] <= 0;
      for (int k = 0; k < 3; k++) begin
         dn[k] = d_ff[7][k][C-1];
         dabs[k*C +: C] = dn[k] ? C'(~d_ff[7][k] + 1'b1) : d_ff[7][k];
         opk[k*C +: C] = o_ff[7][k];
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= {miss, n_ff[DOT_NT], n_ff[DOT_DET], dn, dabs, opk};
   end

   assign push      = push_ff;
   assign push_data = data_ff;
endmodule

>>> src/rti_fifo.sv
// Request queue between the front and back pipelines.
`timescale 1ns / 1ps
module rti_fifo import rti_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);
   logic [WIDTH-1:0]   mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];
endmodule

>>> src/rti_div.sv
// Pipelined restoring divider, several numerators over one shared denominator.
`timescale 1ns / 1ps
module rti_div import rti_pkg::*; #(
   parameter int DEN_W = 67,
   parameter int LANES = 4
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [DEN_W-1:0]          den,
   input  logic [DEN_W+QUO_BITS-1:0] num [LANES],
   output logic [QUO_BITS-1:0]       quo [LANES],
   output logic                      rem_nz [LANES]
);
   localparam int RW = DEN_W + QUO_BITS;

   logic [DEN_W-1:0]    den_ff [QUO_BITS];
   logic [RW-1:0]       r_ff   [QUO_BITS][LANES];
   logic [QUO_BITS-1:0] q_ff   [QUO_BITS][LANES];

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
      logic [DEN_W-1:0]    dp;
      logic [RW-1:0]       rp [LANES];
      logic [QUO_BITS-1:0] qp [LANES];
      logic [RW-1:0]       tr;
      logic [RW-1:0]       r_in [LANES];
      logic [QUO_BITS-1:0] q_in [LANES];

      if (s == 0) begin : g_first
         always_comb begin
            dp = den;
            for (int j = 0; j < LANES; j++) begin
               rp[j] = num[j];
               qp[j] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            dp = den_ff[s-1];
            for (int j = 0; j < LANES; j++) begin
               rp[j] = r_ff[s-1][j];
               qp[j] = q_ff[s-1][j];
            end
         end
      end

      always_comb begin
         tr = RW'(dp) << (QUO_BITS - 1 - s);
         for (int j = 0; j < LANES; j++) begin
            if (rp[j] >= tr) begin
               r_in[j] = rp[j] - tr;
               q_in[j] = {qp[j][QUO_BITS-2:0], 1'b1};
            end else begin
               r_in[j] = rp[j];
               q_in[j] = {qp[j][QUO_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s] <= dp;
            for (int j = 0; j < LANES; j++) begin
               r_ff[s][j] <= r_in[j];
               q_ff[s][j] <= q_in[j];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         quo[j]    = q_ff[QUO_BITS-1][j];
         rem_nz[j] = (r_ff[QUO_BITS-1][j] != '0);
      end
   end
endmodule

>>> src/rti_back.sv
// Back pipeline: distance and hit point divisions, rounding, saturation and result register.
`timescale 1ns / 1ps
module rti_back import rti_pkg::*; #(
   parameter int COORD_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  logic [2*(3*COORD_BITS+7)+6*COORD_BITS+3:0] head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic [31:0]          rsp_hit_distance,
   output logic [FIELD_W-1:0]   rsp_hit_point
);
   localparam int C  = COORD_BITS;
   localparam int DW = 3 * C + 7;
   localparam int CH = C + 3;
   localparam int PP = CH + C;
   localparam int MW = 3 * CH + C;
   localparam int RW = DW + QUO_BITS;
   localparam int TW = DW + DIST_FRAC;
   localparam int PW = 2 * DW + 6 * C + 4;
   localparam int OD = 6 * C + 3;
   localparam logic signed [C+1:0] CMAX = {3'b000, {(C-1){1'b1}}};
   localparam logic signed [C+1:0] CMIN = {3'b111, {(C-1){1'b0}}};

   logic en;
   assign en  = !rsp_valid || rsp_ready;
   assign pop = en && !empty;

   logic                v_ff [0:3];
   logic                miss_ff [0:3];
   logic [DW-1:0]       nt_ff [0:3];
   logic [DW-1:0]       det_ff [0:3];
   logic [2:0]          dneg_ff [0:3];
   logic signed [C-1:0] o_ff [0:3][3];
   logic [C-1:0]        dabs_ff [3];
   logic                tsat_ff [2:3];
   logic [PP-1:0]       pp_ff [3][3];
   logic [MW-1:0]       nm_ff [3];
   logic [RW-1:0]       num_ff [4];
   logic [2:0]          hsat_ff;

   logic                sv_ff [QUO_BITS];
   logic                smiss_ff [QUO_BITS];
   logic                stsat_ff [QUO_BITS];
   logic [2:0]          shsat_ff [QUO_BITS];
   logic [2:0]          sneg_ff [QUO_BITS];
   logic signed [C-1:0] so_ff [QUO_BITS][3];

   logic                rv_ff, rv_in;
   logic                rhit_ff;
   logic [31:0]         rdist_ff;
   logic [FIELD_W-1:0]  rpt_ff;

   logic [3*CH-1:0]     ntx;
   logic [QUO_BITS-1:0] quo [4];
   logic                rem_nz [4];

   always_comb begin
      rv_in = en ? sv_ff[QUO_BITS-1] : rv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= 3; i++) begin
            v_ff[i] <= 1'b0;
         end
         for (int i = 0; i < QUO_BITS; i++) begin
            sv_ff[i] <= 1'b0;
         end
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
         if (en) begin
            v_ff[0] <= !empty;
            for (int i = 1; i <= 3; i++) begin
               v_ff[i] <= v_ff[i-1];
            end
            sv_ff[0] <= v_ff[3];
            for (int i = 1; i < QUO_BITS; i++) begin
               sv_ff[i] <= sv_ff[i-1];
            end
         end
      end
   end

   assign ntx = (3*CH)'(nt_ff[0]);

   always_ff @(posedge clock) begin
      if (en) begin
         miss_ff[0] <= head[PW-1];
         nt_ff[0]   <= head[OD+DW +: DW];
         det_ff[0]  <= head[OD +: DW];
         dneg_ff[0] <= head[6*C +: 3];
         for (int k = 0; k < 3; k++) begin
            dabs_ff[k] <= head[3*C + k*C +: C];
            o_ff[0][k] <= $signed(head[k*C +: C]);
         end
         for (int i = 1; i <= 3; i++) begin
            miss_ff[i] <= miss_ff[i-1];
            nt_ff[i]   <= nt_ff[i-1];
            det_ff[i]  <= det_ff[i-1];
            dneg_ff[i] <= dneg_ff[i-1];
            for (int k = 0; k < 3; k++) begin
               o_ff[i][k] <= o_ff[i-1][k];
            end
         end
         tsat_ff[2] <= TW'(nt_ff[1]) >= (TW'(det_ff[1]) << DIST_FRAC);
         tsat_ff[3] <= tsat_ff[2];
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               pp_ff[k][j] <= PP'(ntx[j*CH +: CH]) * PP'(dabs_ff[k]);
            end
            nm_ff[k] <= MW'(pp_ff[k][0]) + (MW'(pp_ff[k][1]) << CH)
                      + (MW'(pp_ff[k][2]) << (2*CH));
            hsat_ff[k]  <= RW'(nm_ff[k]) >= (RW'(det_ff[2]) << QUO_BITS);
            num_ff[k+1] <= RW'(nm_ff[k]);
         end
         num_ff[0] <= RW'(nt_ff[2]) << DIST_FRAC;

         smiss_ff[0] <= miss_ff[3];
         stsat_ff[0] <= tsat_ff[3];
         shsat_ff[0] <= hsat_ff;
         sneg_ff[0]  <= dneg_ff[3];
         for (int k = 0; k < 3; k++) begin
            so_ff[0][k] <= o_ff[3][k];
         end
         for (int i = 1; i < QUO_BITS; i++) begin
            smiss_ff[i] <= smiss_ff[i-1];
            stsat_ff[i] <= stsat_ff[i-1];
            shsat_ff[i] <= shsat_ff[i-1];
            sneg_ff[i]  <= sneg_ff[i-1];
            for (int k = 0; k < 3; k++) begin
               so_ff[i][k] <= so_ff[i-1][k];
            end
         end
      end
   end

   rti_div #(
      .DEN_W (DW),
      .LANES (4)
   ) u_div (
      .clock  (clock),
      .en     (en),
      .den    (det_ff[3]),
      .num    (num_ff),
      .quo    (quo),
      .rem_nz (rem_nz)
   );

   localparam int LS = QUO_BITS - 1;

   logic [QUO_BITS:0]     qr [3];
   logic [C:0]            mag [3];
   logic signed [C+1:0]   p [3];
   logic [3*C-1:0]        pk;
   logic [3*C+FIELD_W-1:0] pt;
   logic [31:0]           hit_dist;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qr[k] = (QUO_BITS+1)'(quo[k+1]) + (QUO_BITS+1)'(sneg_ff[LS][k] && rem_nz[k+1]);
         if (shsat_ff[LS][k] || qr[k] >= ((QUO_BITS+1)'(1) << C)) begin
            mag[k] = (C+1)'(1) << C;
         end else begin
            mag[k] = qr[k][C:0];
         end
         if (sneg_ff[LS][k]) begin
            p[k] = (C+2)'(so_ff[LS][k]) - $signed({1'b0, mag[k]});
         end else begin
            p[k] = (C+2)'(so_ff[LS][k]) + $signed({1'b0, mag[k]});
         end
         if (p[k] > CMAX) begin
            p[k] = CMAX;
         end else if (p[k] < CMIN) begin
            p[k] = CMIN;
         end
         pk[k*C +: C] = p[k][C-1:0];
      end
      pt       = {{FIELD_W{1'b0}}, pk};
      hit_dist = stsat_ff[LS] ? '1 : quo[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rhit_ff  <= !smiss_ff[LS];
         rdist_ff <= smiss_ff[LS] ? '0 : hit_dist;
         rpt_ff   <= smiss_ff[LS] ? '0 : pt[FIELD_W-1:0];
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_hit          = rhit_ff;
   assign rsp_hit_distance = rdist_ff;
   assign rsp_hit_point    = rpt_ff;
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the ray-triangle intersection block.
`timescale 1ns / 1ps
module tb_top;
   import rti_pkg::*;

   localparam int CB = 20;
   localparam int NUM_RANDOM = 1730;
   localparam int STALL_LIMIT = 4000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [FIELD_W-1:0] origin;
      logic [FIELD_W-1:0] dir;
      logic [FIELD_W-1:0] va;
      logic [FIELD_W-1:0] vb;
      logic [FIELD_W-1:0] vc;
   } ray_tri_type;

   typedef struct {
      logic               hit;
      logic [31:0]        hit_dist;
      logic [FIELD_W-1:0] point;
   } hit_info_type;

   class hit_scoreboard;
      hit_info_type expected_hits[$];
      int errors = 0;
      int hits = 0;
      int results = 0;

      function longint coord(logic [FIELD_W-1:0] v, int k);
         logic signed [CB-1:0] t;
         t = v[k*CB +: CB];
         return t;
      endfunction

      function wide_type dot(longint a[3], longint b[3]);
         return wide_type'(a[0]) * wide_type'(b[0]) + wide_type'(a[1]) * wide_type'(b[1])
              + wide_type'(a[2]) * wide_type'(b[2]);
      endfunction

      function void note_request(ray_tri_type r);
         longint o[3], d[3], va[3], vb[3], vc[3], e1[3], e2[3], s[3], h[3], q[3];
         wide_type det, nu, nv, nt, n, na, quo;
         hit_info_type e;
         longint p;
         longint cmax;
         cmax = (longint'(1) << (CB - 1)) - 1;
         e = '{1'b0, 32'd0, '0};
         for (int k = 0; k < 3; k++) begin
            o[k] = coord(r.origin, k);
            d[k] = coord(r.dir, k);
            va[k] = coord(r.va, k);
            vb[k] = coord(r.vb, k);
            vc[k] = coord(r.vc, k);
            e1[k] = vb[k] - va[k];
            e2[k] = vc[k] - va[k];
            s[k] = o[k] - va[k];
         end
         h[0] = d[1] * e2[2] - d[2] * e2[1];
         h[1] = d[2] * e2[0] - d[0] * e2[2];
         h[2] = d[0] * e2[1] - d[1] * e2[0];
         q[0] = s[1] * e1[2] - s[2] * e1[1];
         q[1] = s[2] * e1[0] - s[0] * e1[2];
         q[2] = s[0] * e1[1] - s[1] * e1[0];
         det = dot(e1, h);
         nu = dot(s, h);
         nv = dot(d, q);
         nt = dot(e2, q);
         if (det < 0) begin
            det = -det;
            nu = -nu;
            nv = -nv;
            nt = -nt;
         end
         if (det != 0 && nu >= 0 && nu <= det && nv >= 0 && nu + nv <= det && nt > 0) begin
            e.hit = 1'b1;
            quo = (nt <<< DIST_FRAC) / det;
            e.hit_dist = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
            for (int k = 0; k < 3; k++) begin
               n = nt * wide_type'(d[k]);
               na = (n < 0) ? -n : n;
               quo = na / det;
               if (n < 0 && (na % det) != 0) quo = quo + 1;
               if (quo > (wide_type'(1) <<< 40)) quo = wide_type'(1) <<< 40;
               p = (n < 0) ? o[k] - longint'(quo) : o[k] + longint'(quo);
               if (p > cmax) p = cmax;
               if (p < -cmax - 1) p = -cmax - 1;
               e.point[k*CB +: CB] = p[CB-1:0];
            end
         end
         expected_hits.push_back(e);
      endfunction

      function void check_result(logic hit, logic [31:0] hit_dist, logic [FIELD_W-1:0] point);
         hit_info_type e;
         results++;
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result hit=%0b distance=%h point=%h", $time, hit,
                     hit_dist, point);
            errors++;
            return;
         end
         e = expected_hits.pop_front();
         if (hit) hits++;
         if (hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
            errors++;
         end
         if (hit_dist !== e.hit_dist) begin
            $display("%0t: hit_distance expected %h actual %h", $time, e.hit_dist, hit_dist);
            errors++;
         end
         if (point !== e.point) begin
            $display("%0t: hit_point expected %h actual %h", $time, e.point, point);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [FIELD_W-1:0] req_ray_origin = '0;
   logic [FIELD_W-1:0] req_ray_direction = '0;
   logic [FIELD_W-1:0] req_vertex_a = '0;
   logic [FIELD_W-1:0] req_vertex_b = '0;
   logic [FIELD_W-1:0] req_vertex_c = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic [31:0]        rsp_hit_distance;
   logic [FIELD_W-1:0] rsp_hit_point;

   hit_scoreboard sb = new();
   int  idle_pct = 10;
   bit  hold_request = 1'b0;
   int  hold_count = 0;
   int  quiet_cycles = 0;

   ray_triangle_intersect u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ray_origin(req_ray_origin), .req_ray_direction(req_ray_direction),
      .req_vertex_a(req_vertex_a), .req_vertex_b(req_vertex_b),
      .req_vertex_c(req_vertex_c),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_hit_distance(rsp_hit_distance), .rsp_hit_point(rsp_hit_point)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (hold_request && hold_count == 0) begin
         hold_count <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_count > 1) begin
         hold_count <= hold_count - 1;
         rsp_ready <= 1'b0;
      end else begin
         hold_count <= 0;
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request('{req_ray_origin, req_ray_direction, req_vertex_a, req_vertex_b,
                           req_vertex_c});
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_hit, rsp_hit_distance, rsp_hit_point);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no progress for %0d cycles.", STALL_LIMIT);
         $display("[ray_triangle_intersect] ERROR");
         $finish;
      end
   end

   function automatic logic [FIELD_W-1:0] pack(longint x, longint y, longint z);
      return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
   endfunction

   function automatic longint clamp(longint v);
      longint m;
      m = (longint'(1) << (CB - 1)) - 1;
      return (v > m) ? m : ((v < -m - 1) ? -m - 1 : v);
   endfunction

   function automatic longint rnd(longint r);
      return longint'($urandom_range(2 * r)) - r;
   endfunction

   function automatic logic [FIELD_W-1:0] rand_field();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[FIELD_W-1:0];
   endfunction

   function automatic ray_tri_type aimed_request();
      ray_tri_type r;
      longint a[3], b[3], c[3], o[3], d[3], tgt;
      longint sc, w1, w2, sh;
      case ($urandom_range(2))
         0: sc = 256;
         1: sc = 4096;
         default: sc = 250000;
      endcase
      w1 = $urandom_range(1024);
      w2 = $urandom_range(1024);
      if (w1 + w2 > 1024) begin
         w1 = 1024 - w1;
         w2 = 1024 - w2;
      end
      sh = $urandom_range(3);
      for (int k = 0; k < 3; k++) begin
         a[k] = rnd(sc);
         b[k] = rnd(sc);
         c[k] = rnd(sc);
         o[k] = rnd(sc);
         tgt = a[k] + (w1 * (b[k] - a[k]) + w2 * (c[k] - a[k])) / 1024;
         d[k] = clamp((tgt - o[k]) >>> sh);
         if ($urandom_range(9) == 0) d[k] = -d[k];
      end
      r.origin = pack(o[0], o[1], o[2]);
      r.dir = pack(d[0], d[1], d[2]);
      r.va = pack(a[0], a[1], a[2]);
      r.vb = pack(b[0], b[1], b[2]);
      r.vc = pack(c[0], c[1], c[2]);
      return r;
   endfunction

   task automatic send_request(ray_tri_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ray_origin <= r.origin;
      req_ray_direction <= r.dir;
      req_vertex_a <= r.va;
      req_vertex_b <= r.vb;
      req_vertex_c <= r.vc;
      do @(posedge clock); while (!req_ready);
   endtask

   ray_tri_type directed[$];
   ray_tri_type item;
   longint one, big;

   initial begin
      one = 1024;
      big = (longint'(1) << (CB - 1)) - 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back('{'0, '0, '0, '0, '0});
      directed.push_back('{'1, '1, '1, '1, '1});
      item.va = pack(0, 0, 0);
      item.vb = pack(one, 0, 0);
      item.vc = pack(0, one, 0);
      item.origin = pack(0, 0, one);
      item.dir = pack(0, 0, -one);
      directed.push_back(item);
      item.dir = pack(0, 0, one);
      directed.push_back(item);
      item.origin = pack(one, 0, one);
      item.dir = pack(0, 0, -one);
      directed.push_back(item);
      item.origin = pack(one / 2, one / 2, one);
      directed.push_back(item);
      item.origin = pack(one / 2 + 1, one / 2, one);
      directed.push_back(item);
      item.origin = pack(-1, 0, one);
      directed.push_back(item);
      item.origin = pack(0, 0, 0);
      directed.push_back(item);
      item.origin = pack(1, 1, big);
      item.dir = pack(0, 0, -1);
      directed.push_back(item);
      item.origin = pack(1, 1, 1);
      item.dir = pack(0, 0, -big - 1);
      directed.push_back(item);
      item.origin = pack(10, 10, big);
      item.dir = pack(big, -big - 1, -1);
      directed.push_back(item);
      item.origin = pack(10, 10, one);
      item.dir = pack(one, 0, 0);
      directed.push_back(item);
      item.va = pack(big, big, 0);
      item.vb = pack(-big - 1, big, 0);
      item.vc = pack(big, -big - 1, 0);
      item.origin = pack(0, 0, -big - 1);
      item.dir = pack(1, 1, 1);
      directed.push_back(item);
      item.vb = item.va;
      directed.push_back(item);
      foreach (directed[i]) send_request(directed[i]);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         idle_pct = (i >= 400 && i < 700) ? 0 : 10;
         if (i == 900) hold_request = 1'b1;
         if (i == 901) hold_request = 1'b0;
         case ($urandom_range(9))
            0, 1: item = '{rand_field(), rand_field(), rand_field(), rand_field(),
                           rand_field()};
            2: begin
               item = aimed_request();
               item.dir = rand_field();
            end
            default: item = aimed_request();
         endcase
         send_request(item);
      end
      req_valid <= 1'b0;

      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Ran %0d requests (%0d directed, rest random or aimed), %0d results, %0d hits.",
               directed.size() + NUM_RANDOM, directed.size(), sb.results, sb.hits);
      $display("Coverage included idle-free bursts and a long result-side stall.");
      if (sb.errors == 0)
         $display("[ray_triangle_intersect] OK");
      else
         $display("[ray_triangle_intersect] ERROR");
      $finish;
   end
endmodule
